FILE: src/scsa_pkg.sv
// Shared types, codes and constants of the size-class slab allocator.
// Has no dependencies; the controller, datapath and top refer to it by scoped names.
`timescale 1ns / 1ps
package scsa_pkg;

  localparam int HEAP_W     = 29;
  localparam int FIELD_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;
  localparam int CLASS_W    = 4;
  localparam int BELL_W     = 14;
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 2'd1;

  // Bell curve share of the heap per class, Q0.16, symmetric.
  function automatic logic [BELL_W-1:0] bell_q16(input logic [3:0] idx);
    logic [2:0] k;
    logic [BELL_W-1:0] v;
    k = idx[3] ? ~idx[2:0] : idx[2:0];
    unique case (k)
      3'd0: v = 14'd124;
      3'd1: v = 14'd367;
      3'd2: v = 14'd956;
      3'd3: v = 14'd2097;
      3'd4: v = 14'd3951;
      3'd5: v = 14'd6343;
      3'd6: v = 14'd8696;
      3'd7: v = 14'd10184;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic                init;
    logic                clr_step;
    logic                capture;
    logic                scan_step;
    logic                fsrch_step;
    logic                fread;
    logic                alloc_set;
    logic                fclear;
    logic                load;
    logic [STATUS_W-1:0] res;
  } cmd_t;

  typedef struct packed {
    logic build_done;
    logic req_free;
    logic too_large;
    logic cnt_zero;
    logic hit;
    logic scan_end;
    logic fmatch;
    logic flast;
    logic out_busy;
    logic cfg_hit;
  } sts_t;

endpackage

FILE: src/scsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module scsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/scsa_ctrl.sv
// Controller state machine of the slab allocator.
// Depends on scsa_pkg for the command and status structs and result codes.
`timescale 1ns / 1ps
module scsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scsa_pkg::sts_t    sts_i,
  output scsa_pkg::cmd_t    cmd_o
);
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FSRCH = 3'd5;
  localparam logic [2:0] S_FWR   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res  = scsa_pkg::ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.build_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        // Wait for the output register to drain before producing a result.
        if (!sts_i.out_busy) begin
          priority if (sts_i.req_free) begin
            state_d = S_FSRCH;
          end else if (sts_i.too_large) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = scsa_pkg::ST_TOO_LARGE;
            state_d    = S_IDLE;
          end else if (sts_i.cnt_zero) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = scsa_pkg::ST_FULL;
            state_d    = S_IDLE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        priority if (sts_i.hit) begin
          cmd_o.alloc_set = 1'b1;
          cmd_o.load      = 1'b1;
          state_d         = S_IDLE;
        end else if (sts_i.scan_end) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = scsa_pkg::ST_FULL;
          state_d    = S_IDLE;
        end
      end
      S_FSRCH: begin
        priority if (sts_i.fmatch) begin
          cmd_o.fread = 1'b1;
          state_d     = S_FWR;
        end else if (sts_i.flast) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = scsa_pkg::ST_NOT_FOUND;
          state_d    = S_IDLE;
        end else begin
          cmd_o.fsrch_step = 1'b1;
        end
      end
      S_FWR: begin
        cmd_o.fclear = 1'b1;
        cmd_o.load   = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
    // A write to the heap-size or data-base register rebuilds the tables and clears the bitmap.
    if (sts_i.cfg_hit) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: src/scsa_dp.sv
// Datapath of the slab allocator: registers, class tables, bitmap RAM, result register.
// Depends on scsa_pkg and scsa_ram.
`timescale 1ns / 1ps
module scsa_dp #(
  parameter int NumClasses = 16,
  parameter int MinShift   = 5,
  parameter int MaxSlots   = 1024,
  parameter int AddrWidth  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                req_type_i,
  input  logic [scsa_pkg::FIELD_W-1:0]        request_size_i,
  input  logic [scsa_pkg::FIELD_W-1:0]        free_address_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [scsa_pkg::STATUS_W-1:0]       status_o,
  output logic [scsa_pkg::FIELD_W-1:0]        slot_address_o,
  output logic [scsa_pkg::CLASS_W-1:0]        size_class_o,
  input  scsa_pkg::cmd_t                      cmd_i,
  output scsa_pkg::sts_t                      sts_o
);
  localparam int Words = (MaxSlots + 31) / 32;
  localparam int Depth = NumClasses * Words;
  localparam int RAW   = Depth > 1 ? $clog2(Depth) : 1;
  localparam int CW    = NumClasses > 1 ? $clog2(NumClasses) : 1;
  localparam int BCW   = $clog2(NumClasses + 1);
  localparam int SCW   = $clog2(MaxSlots + 1);
  localparam int RWW   = $clog2(Words + 1);
  localparam int CLW   = $clog2(Depth + 1);
  localparam int PW    = scsa_pkg::BELL_W + scsa_pkg::HEAP_W;
  localparam int WB    = scsa_pkg::WORD_BITS;

  // Configuration registers.
  logic [scsa_pkg::HEAP_W-1:0]  heap_q;
  logic [scsa_pkg::FIELD_W-1:0] base_q;
  logic                         cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i == scsa_pkg::CFG_HEAP_SIZE ||
                                cfg_index_i == scsa_pkg::CFG_DATA_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == scsa_pkg::CFG_HEAP_SIZE) begin
        heap_q <= cfg_wdata_i[scsa_pkg::HEAP_W-1:0];
      end else if (cfg_index_i == scsa_pkg::CFG_DATA_BASE) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  // Class tables, rebuilt one class at a time: a multiply step, then a store step.
  logic [SCW-1:0]       cnt_q   [NumClasses];
  logic [AddrWidth-1:0] start_q [NumClasses];
  logic [BCW-1:0]       bc_q;
  logic                 bp_q;
  logic [PW-1:0]        prod_q;
  logic [AddrWidth-1:0] addr_q;
  logic [CLW-1:0]       clr_q;
  logic [5:0]           bsh;
  logic [PW-1:0]        bn;
  logic [PW-1:0]        bn_sat;
  logic                 build_done;

  assign bsh    = 6'(bc_q[CW-1:0]) + 6'(MinShift);
  assign bn     = prod_q >> (7'(scsa_pkg::FRAC_BITS) + 7'(bsh));
  assign bn_sat = (bn > PW'(MaxSlots)) ? PW'(MaxSlots) : bn;
  assign build_done = (bc_q == BCW'(NumClasses)) && (clr_q == CLW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q  <= '0;
      bp_q  <= 1'b0;
      clr_q <= '0;
    end else if (cmd_i.init) begin
      bc_q  <= '0;
      bp_q  <= 1'b0;
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      if (clr_q != CLW'(Depth)) begin
        clr_q <= clr_q + 1'b1;
      end
      if (bc_q != BCW'(NumClasses)) begin
        bp_q <= ~bp_q;
        if (bp_q) begin
          bc_q <= bc_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      addr_q <= AddrWidth'(base_q);
    end else if (cmd_i.clr_step && bc_q != BCW'(NumClasses)) begin
      if (!bp_q) begin
        prod_q <= PW'(scsa_pkg::bell_q16(4'(bc_q[CW-1:0]))) * PW'(heap_q);
      end else begin
        cnt_q[bc_q[CW-1:0]]   <= SCW'(bn_sat);
        start_q[bc_q[CW-1:0]] <= addr_q;
        addr_q <= addr_q + (AddrWidth'(bn_sat) << bsh);
      end
    end
  end

  // Request capture and class decode.
  logic                 free_q;
  logic                 tl_q;
  logic [CW-1:0]        cls_q;
  logic [AddrWidth-1:0] faddr_q;
  logic [CW-1:0]        dcls;
  logic                 dtl;

  always_comb begin
    dcls = '0;
    dtl  = 1'b1;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if ((64'd1 << (c + MinShift)) >= 64'(request_size_i)) begin
        dcls = CW'(c);
        dtl  = 1'b0;
      end
    end
  end

  // Scan and free-search state.
  logic [RWW-1:0]       rd_w_q;
  logic [RWW-1:0]       chk_q;
  logic                 rv_q;
  logic [CW-1:0]        fc_q;
  logic [SCW-1:0]       fslot_q;
  logic [WB-1:0]        rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (cmd_i.capture) begin
      rv_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      rv_q <= SCW'(rd_w_q) < ((cnt_q[cls_q] + SCW'(WB - 1)) >> 5);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      free_q  <= req_type_i;
      tl_q    <= dtl;
      cls_q   <= dcls;
      faddr_q <= AddrWidth'(free_address_i);
      rd_w_q  <= '0;
      fc_q    <= '0;
    end else begin
      if (cmd_i.scan_step) begin
        rd_w_q <= rd_w_q + 1'b1;
        chk_q  <= rd_w_q;
      end
      if (cmd_i.fsrch_step) begin
        fc_q <= fc_q + 1'b1;
      end
    end
  end

  // Allocate: first free bit of the word that just came back.
  logic [SCW-1:0]  acnt;
  logic [SCW-1:0]  nwords;
  logic [SCW-1:0]  rem;
  logic [WB-1:0]   avail;
  logic [4:0]      abit;
  logic [SCW-1:0]  aslot;
  logic [5:0]      ash;
  logic [AddrWidth-1:0] aaddr;

  assign acnt   = cnt_q[cls_q];
  assign nwords = (acnt + SCW'(WB - 1)) >> 5;
  assign rem    = acnt - (SCW'(chk_q) << 5);
  assign ash    = 6'(cls_q) + 6'(MinShift);

  always_comb begin
    avail = '0;
    abit  = '0;
    for (int i = 0; i < WB; i++) begin
      avail[i] = !rdata[i] && (SCW'(i) < rem);
    end
    for (int i = WB - 1; i >= 0; i--) begin
      if (avail[i]) begin
        abit = 5'(i);
      end
    end
  end

  assign aslot = (SCW'(chk_q) << 5) | SCW'(abit);
  assign aaddr = start_q[cls_q] + (AddrWidth'(aslot) << ash);

  // Free: does the address start a slot of class fc_q?
  logic [AddrWidth-1:0] foff;
  logic [AddrWidth-1:0] fj;
  logic [5:0]           fsh;
  logic                 fmatch;

  assign fsh    = 6'(fc_q) + 6'(MinShift);
  assign foff   = faddr_q - start_q[fc_q];
  assign fj     = foff >> fsh;
  assign fmatch = (cnt_q[fc_q] != '0) &&
                  ((foff & ((AddrWidth'(1) << fsh) - 1'b1)) == '0) &&
                  (fj < AddrWidth'(cnt_q[fc_q]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.fread) begin
      fslot_q <= SCW'(fj);
    end
  end

  // Bitmap RAM ports.
  logic           we;
  logic [RAW-1:0] waddr;
  logic [RAW-1:0] raddr;
  logic [WB-1:0]  wdata;

  always_comb begin
    we    = 1'b0;
    waddr = RAW'(clr_q);
    wdata = '0;
    raddr = RAW'(cls_q) * RAW'(Words) + RAW'(rd_w_q);
    if (cmd_i.fread) begin
      raddr = RAW'(fc_q) * RAW'(Words) + RAW'(fj >> 5);
    end
    priority if (cmd_i.clr_step) begin
      we = clr_q != CLW'(Depth);
    end else if (cmd_i.alloc_set) begin
      we    = 1'b1;
      waddr = RAW'(cls_q) * RAW'(Words) + RAW'(chk_q);
      wdata = rdata | (WB'(1) << abit);
    end else if (cmd_i.fclear) begin
      we    = 1'b1;
      waddr = RAW'(fc_q) * RAW'(Words) + RAW'(fslot_q >> 5);
      wdata = rdata & ~(WB'(1) << fslot_q[4:0]);
    end
  end

  scsa_ram #(
    .Width (WB),
    .Depth (Depth)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o       <= cmd_i.res;
      slot_address_o <= '0;
      size_class_o   <= '0;
      if (cmd_i.res == scsa_pkg::ST_OK && free_q) begin
        size_class_o <= scsa_pkg::CLASS_W'(fc_q);
      end else if (cmd_i.res == scsa_pkg::ST_OK) begin
        size_class_o   <= scsa_pkg::CLASS_W'(cls_q);
        slot_address_o <= scsa_pkg::FIELD_W'(aaddr);
      end else if (cmd_i.res == scsa_pkg::ST_FULL) begin
        size_class_o <= scsa_pkg::CLASS_W'(cls_q);
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.build_done = build_done;
    sts_o.req_free   = free_q;
    sts_o.too_large  = tl_q;
    sts_o.cnt_zero   = acnt == '0;
    sts_o.hit        = rv_q && (avail != '0);
    sts_o.scan_end   = rv_q && (SCW'(chk_q) == nwords - 1'b1);
    sts_o.fmatch     = fmatch;
    sts_o.flast      = fc_q == CW'(NumClasses - 1);
    sts_o.out_busy   = out_valid_o;
    sts_o.cfg_hit    = cfg_hit;
  end
endmodule

FILE: src/size_class_slab_allocator.sv
// Slab allocator: an allocate scans W bitmap words (up to 32 by default), or answers at
// decode when the request is too large or its class has no slots; a free searches
// the classes in turn; one request is worked on at a time.
// The bitmap RAM read port, one word per cycle, paces the allocate scan.
// After reset and after a write to the heap-size or data-base register the block runs a
// clearing pass over all NumClasses * ceil(MaxSlots/32) bitmap words and takes no request then.
`timescale 1ns / 1ps
module size_class_slab_allocator #(
  parameter int NumClasses = 16,
  parameter int MinShift   = 5,
  parameter int MaxSlots   = 1024,
  parameter int AddrWidth  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [scsa_pkg::FIELD_W-1:0]     request_size_i,
  input  logic [scsa_pkg::FIELD_W-1:0]     free_address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [scsa_pkg::STATUS_W-1:0]    status_o,
  output logic [scsa_pkg::FIELD_W-1:0]     slot_address_o,
  output logic [scsa_pkg::CLASS_W-1:0]     size_class_o
);
  // The controller sequences each request through decode, bitmap scan or
  // class search, and the final bitmap write. The datapath holds the class
  // tables (slot counts and region starts, rebuilt with one shared multiplier
  // during the clearing pass), the used bitmap RAM and the result register.
  // A finished result sits in the result register, so the next request is
  // accepted while it waits; that request then stalls in decode until the
  // result register empties.
  scsa_pkg::cmd_t cmd;
  scsa_pkg::sts_t sts;

  scsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scsa_dp #(
    .NumClasses (NumClasses),
    .MinShift   (MinShift),
    .MaxSlots   (MaxSlots),
    .AddrWidth  (AddrWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .slot_address_o (slot_address_o),
    .size_class_o   (size_class_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

`ifndef SYNTH
  // A result is only loaded into an empty result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !out_valid_o)
    else $error("result loaded over a pending result");

  // After a request is taken the block takes no other request in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted back to back");

  // A valid register write starts a rebuild, so no request is taken next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.cfg_hit |=> !in_ready_o)
    else $error("request taken during rebuild");

  // Only a successful allocate carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != scsa_pkg::ST_OK) |-> slot_address_o == '0)
    else $error("address on a failed request");
`endif
endmodule
